>>> src/onf_pkg.sv
`default_nettype none
package onf_pkg;

  localparam int COORD_W   = 16;
  localparam int COEFF_W   = 15;
  localparam int COS_W     = 16;
  localparam int FACTOR_W  = 19;
  localparam int CFG_IDX_W = 2;
  localparam int P_W       = 24;   // tangent projection, Q.20
  localparam int NORM_W    = 46;   // squared projection length
  localparam int DOT_W     = 47;   // projection dot product, signed
  localparam int ROOT_W    = NORM_W / 2;
  localparam int SINE_W    = 15;
  localparam int CPHI_W    = 15;
  localparam int NUM1_W    = 61;   // cosphi dividend
  localparam int TERM_Q_W  = 20;   // term quotient bits before saturation
  localparam int NUM2_W    = 35;

  localparam logic signed [COS_W-1:0] COS_ONE   = 16'sd16384;
  localparam logic signed [COS_W-1:0] COS_LIMIT = 16'sd16383;
  localparam logic [CPHI_W-1:0]       CPHI_ONE  = 15'd16384;

  localparam logic signed [FACTOR_W-1:0] FACTOR_MAX = 19'h3FFFF;
  localparam logic signed [FACTOR_W-1:0] FACTOR_MIN = 19'h40000;

  localparam logic [COEFF_W-1:0] COEFF_A_RST = 15'd16143;
  localparam logic [COEFF_W-1:0] COEFF_B_RST = 15'd737;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_B = 2'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_dir_x;
    logic signed [COORD_W-1:0] in_dir_y;
    logic signed [COORD_W-1:0] in_dir_z;
    logic signed [COORD_W-1:0] out_dir_x;
    logic signed [COORD_W-1:0] out_dir_y;
    logic signed [COORD_W-1:0] out_dir_z;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FACTOR_W-1:0] factor;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [COS_W-1:0] ci;
    logic signed [COS_W-1:0] co;
    logic                    proj_en;
    logic signed [DOT_W-1:0] dt;
    logic [NORM_W-1:0]       n1;
    logic [NORM_W-1:0]       n2;
  } front_t;

endpackage
`default_nettype wire

>>> src/onf_delay.sv
`default_nettype none
module onf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  output logic [W-1:0]      out_data
);

  logic [DEPTH-1:0] vld;
  logic [W-1:0]     data [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    data[0] <= in_data;
    for (int k = 1; k < DEPTH; k++) begin
      data[k] <= data[k-1];
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule
`default_nettype wire

>>> src/onf_isqrt.sv
`default_nettype none
// Floor square root, one result bit per stage.
module onf_isqrt #(
  parameter int IN_W = 46
) (
  input  wire logic              clk,
  input  wire logic [IN_W-1:0]   radicand,
  output logic [IN_W/2-1:0]      root
);

  localparam int STAGES = IN_W / 2;

  logic [IN_W-1:0] rad_q  [STAGES];
  logic [IN_W-1:0] root_q [STAGES];
  logic [IN_W-1:0] rad_d  [STAGES];
  logic [IN_W-1:0] root_d [STAGES];

  always_comb begin
    logic [IN_W-1:0] src_rad;
    logic [IN_W-1:0] src_root;
    logic [IN_W-1:0] bitv;
    logic [IN_W:0]   trial;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        src_rad  = radicand;
        src_root = '0;
      end else begin
        src_rad  = rad_q[k-1];
        src_root = root_q[k-1];
      end
      bitv  = IN_W'(1) << (IN_W - 2 - 2 * k);
      trial = {1'b0, src_root} + {1'b0, bitv};
      if ({1'b0, src_rad} >= trial) begin
        rad_d[k]  = src_rad - trial[IN_W-1:0];
        root_d[k] = (src_root >> 1) + bitv;
      end else begin
        rad_d[k]  = src_rad;
        root_d[k] = src_root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      rad_q[k]  <= rad_d[k];
      root_q[k] <= root_d[k];
    end
  end

  assign root = root_q[STAGES-1][IN_W/2-1:0];

endmodule
`default_nettype wire

>>> src/onf_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage, MSB first.
// Caller keeps num below den * 2^Q_W and DEN_W + Q_W - 1 <= NUM_W.
module onf_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 46,
  parameter int Q_W   = 15
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]        quo
);

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [NUM_W-1:0] rem_d [Q_W];
  logic [Q_W-1:0]   quo_d [Q_W];

  always_comb begin
    logic [NUM_W-1:0] src_rem;
    logic [DEN_W-1:0] src_den;
    logic [Q_W-1:0]   src_quo;
    logic [NUM_W-1:0] sh;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        src_rem = num;
        src_den = den;
        src_quo = '0;
      end else begin
        src_rem = rem_q[k-1];
        src_den = den_q[k-1];
        src_quo = quo_q[k-1];
      end
      sh = NUM_W'(src_den) << (Q_W - 1 - k);
      if (src_rem >= sh) begin
        rem_d[k] = src_rem - sh;
        quo_d[k] = src_quo | (Q_W'(1) << (Q_W - 1 - k));
      end else begin
        rem_d[k] = src_rem;
        quo_d[k] = src_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
      den_q[k] <= (k == 0) ? den : den_q[(k == 0) ? 0 : k-1];
    end
  end

  assign quo = quo_q[Q_W-1];

endmodule
`default_nettype wire

>>> src/onf_front.sv
`default_nettype none
// Cosines against the normal, tangent projections and their dot products.
module onf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire onf_pkg::in_item_t item,
  output logic                   out_valid,
  output onf_pkg::front_t        res
);

  localparam int CW = onf_pkg::COS_W;
  localparam int PW = onf_pkg::P_W;

  logic [5:0] vld;

  logic signed [15:0] wi [3];
  logic signed [15:0] wo [3];
  logic signed [15:0] nv [3];

  logic signed [15:0] s1_wi [3], s1_wo [3], s1_nv [3];
  logic signed [31:0] s1_pi [3], s1_po [3];

  logic signed [15:0] s2_wi [3], s2_wo [3], s2_nv [3];
  logic signed [CW-1:0] s2_ci, s2_co;

  logic signed [15:0] s3_wi [3], s3_wo [3];
  logic signed [31:0] s3_mi [3], s3_mo [3];
  logic signed [CW-1:0] s3_ci, s3_co;

  logic signed [PW-1:0] s4_p [3], s4_q [3];
  logic signed [CW-1:0] s4_ci, s4_co;
  logic                 s4_en;

  logic signed [2*PW-1:0] s5_d [3], s5_a [3], s5_b [3];
  logic signed [CW-1:0]   s5_ci, s5_co;
  logic                   s5_en;

  function automatic logic signed [CW-1:0] clamp_cos(input logic signed [33:0] sum);
    logic signed [33:0] t;
    t = (sum + 34'sd8192) >>> 14;
    if (t > 34'sd16384) begin
      clamp_cos = onf_pkg::COS_ONE;
    end else if (t < -34'sd16384) begin
      clamp_cos = -onf_pkg::COS_ONE;
    end else begin
      clamp_cos = CW'(t);
    end
  endfunction

  function automatic logic signed [PW-1:0] project(input logic signed [15:0] w,
                                                   input logic signed [31:0] m);
    logic signed [33:0] t;
    t = ((34'(w) <<< 14) - 34'(m) + 34'sd128) >>> 8;
    project = PW'(t);
  endfunction

  always_comb begin
    wi[0] = item.in_dir_x;  wi[1] = item.in_dir_y;  wi[2] = item.in_dir_z;
    wo[0] = item.out_dir_x; wo[1] = item.out_dir_y; wo[2] = item.out_dir_z;
    nv[0] = item.normal_x;  nv[1] = item.normal_y;  nv[2] = item.normal_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_wi[k] <= wi[k];
      s1_wo[k] <= wo[k];
      s1_nv[k] <= nv[k];
      s1_pi[k] <= 32'(wi[k]) * 32'(nv[k]);
      s1_po[k] <= 32'(wo[k]) * 32'(nv[k]);
    end

    s2_wi <= s1_wi;
    s2_wo <= s1_wo;
    s2_nv <= s1_nv;
    s2_ci <= clamp_cos(34'(s1_pi[0]) + 34'(s1_pi[1]) + 34'(s1_pi[2]));
    s2_co <= clamp_cos(34'(s1_po[0]) + 34'(s1_po[1]) + 34'(s1_po[2]));

    s3_wi <= s2_wi;
    s3_wo <= s2_wo;
    s3_ci <= s2_ci;
    s3_co <= s2_co;
    for (int k = 0; k < 3; k++) begin
      s3_mi[k] <= 32'(s2_nv[k]) * 32'(s2_ci);
      s3_mo[k] <= 32'(s2_nv[k]) * 32'(s2_co);
    end

    for (int k = 0; k < 3; k++) begin
      s4_p[k] <= project(s3_wi[k], s3_mi[k]);
      s4_q[k] <= project(s3_wo[k], s3_mo[k]);
    end
    s4_ci <= s3_ci;
    s4_co <= s3_co;
    s4_en <= (s3_ci < onf_pkg::COS_LIMIT) && (s3_co < onf_pkg::COS_LIMIT);

    for (int k = 0; k < 3; k++) begin
      s5_d[k] <= (2*PW)'(s4_p[k]) * (2*PW)'(s4_q[k]);
      s5_a[k] <= (2*PW)'(s4_p[k]) * (2*PW)'(s4_p[k]);
      s5_b[k] <= (2*PW)'(s4_q[k]) * (2*PW)'(s4_q[k]);
    end
    s5_ci <= s4_ci;
    s5_co <= s4_co;
    s5_en <= s4_en;

    res.ci      <= s5_ci;
    res.co      <= s5_co;
    res.proj_en <= s5_en;
    res.dt      <= onf_pkg::DOT_W'(s5_d[0] + s5_d[1] + s5_d[2]);
    res.n1      <= onf_pkg::NORM_W'($unsigned(s5_a[0] + s5_a[1] + s5_a[2]));
    res.n2      <= onf_pkg::NORM_W'($unsigned(s5_b[0] + s5_b[1] + s5_b[2]));
  end

  assign out_valid = vld[5];

endmodule
`default_nettype wire

>>> src/oren_nayar_diffuse_factor.sv
`default_nettype none
// Throughput: one item per cycle; busy is never asserted.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Depth is set by the four parallel 23-stage square-root units and the 15- and
// 20-stage restoring dividers on the result path.
// Synchronous reset clears all valid bits and reloads coeff_a and coeff_b.
module oren_nayar_diffuse_factor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire onf_pkg::in_item_t                 item,
  output logic                                   result_valid,
  output onf_pkg::out_item_t                     result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [onf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [onf_pkg::COEFF_W-1:0]       cfg_data
);

  localparam int CW     = onf_pkg::COS_W;
  localparam int NW     = onf_pkg::NORM_W;
  localparam int DW     = onf_pkg::DOT_W;
  localparam int RW     = onf_pkg::ROOT_W;
  localparam int SW     = onf_pkg::SINE_W;
  localparam int PHW    = onf_pkg::CPHI_W;
  localparam int N1W    = onf_pkg::NUM1_W;
  localparam int N2W    = onf_pkg::NUM2_W;
  localparam int TQW    = onf_pkg::TERM_Q_W;
  localparam int KW     = onf_pkg::COEFF_W;
  localparam int SIDE1W = DW + 1 + CW;
  localparam int SIDE2W = 2 + CW + 2 * SW;

  logic [KW-1:0] coeff_a, coeff_b;

  logic             fr_valid;
  onf_pkg::front_t  fr;

  // stage A
  logic                 a_valid;
  logic [NW-1:0]        a_n1, a_n2, a_sa_arg, a_sb_arg;
  logic signed [DW-1:0] a_dt;
  logic                 a_en;
  logic signed [CW-1:0] a_cb;
  logic signed [CW-1:0] ca, cb;
  logic signed [32:0]   ca_sq, cb_sq;

  logic [RW-1:0] r1, r2, rsa, rsb;
  logic               i_valid;
  logic [SIDE1W-1:0]  i_side;

  // stage B
  logic                 b_valid;
  logic [NW-1:0]        b_den;
  logic [2*SW-1:0]      b_sab;
  logic signed [DW-1:0] b_dt;
  logic                 b_en;
  logic signed [CW-1:0] b_cb;

  // stage C
  logic                 c_valid;
  logic [N1W-1:0]       c_num;
  logic [NW-1:0]        c_den;
  logic [SIDE2W-1:0]    c_side;
  logic [N1W-1:0]       n_full, n_lim;
  logic                 c_pos, c_big;

  logic [PHW-1:0]       q1;
  logic                 j_valid;
  logic [SIDE2W-1:0]    j_side;
  logic                 j_zero, j_big;
  logic signed [CW-1:0] j_cb;
  logic [2*SW-1:0]      j_sab;

  // stages D, E, F
  logic                 d_valid, e_valid, f_valid;
  logic [PHW-1:0]       d_cphi;
  logic [2*SW-1:0]      d_sab, e_sab;
  logic signed [CW-1:0] d_cb, e_cb, f_cb;
  logic [2*SW-1:0]      e_pb;
  logic [4*SW-1:0]      f_prod;

  // stage G
  logic                 g_valid;
  logic [N2W-1:0]       g_num;
  logic [SW-1:0]        g_den;
  logic [2:0]           g_side;
  logic [SW-1:0]        m;
  logic [60:0]          xs;
  logic [32:0]          xq;
  logic                 g_zero, g_big;

  logic [TQW-1:0]       q2;
  logic                 h_valid;
  logic [2:0]           h_side;
  logic                 h_neg, h_zero, h_big;
  logic signed [21:0]   h_sum;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a <= onf_pkg::COEFF_A_RST;
      coeff_b <= onf_pkg::COEFF_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        onf_pkg::REG_COEFF_A: coeff_a <= cfg_data;
        onf_pkg::REG_COEFF_B: coeff_b <= cfg_data;
        default: ;
      endcase
    end
  end

  onf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .item      (item),
    .out_valid (fr_valid),
    .res       (fr)
  );

  // stage A: pick larger / smaller cosine, sine radicands
  always_comb begin
    if (fr.co >= fr.ci) begin
      cb = fr.co;
      ca = fr.ci;
    end else begin
      cb = fr.ci;
      ca = fr.co;
    end
    ca_sq = 33'(ca) * 33'(ca);
    cb_sq = 33'(cb) * 33'(cb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= fr_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_n1     <= fr.n1;
    a_n2     <= fr.n2;
    a_sa_arg <= NW'($unsigned(33'sd268435456 - ca_sq));
    a_sb_arg <= NW'($unsigned(33'sd268435456 - cb_sq));
    a_dt     <= fr.dt;
    a_en     <= fr.proj_en;
    a_cb     <= cb;
  end

  onf_isqrt #(.IN_W(NW)) u_sqrt_n1 (.clk(clk), .radicand(a_n1),     .root(r1));
  onf_isqrt #(.IN_W(NW)) u_sqrt_n2 (.clk(clk), .radicand(a_n2),     .root(r2));
  onf_isqrt #(.IN_W(NW)) u_sqrt_sa (.clk(clk), .radicand(a_sa_arg), .root(rsa));
  onf_isqrt #(.IN_W(NW)) u_sqrt_sb (.clk(clk), .radicand(a_sb_arg), .root(rsb));

  onf_delay #(.W(SIDE1W), .DEPTH(RW)) u_dly_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_data   ({a_dt, a_en, a_cb}),
    .out_valid (i_valid),
    .out_data  (i_side)
  );

  // stage B: denominator and sine product
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_den <= NW'(r1) * NW'(r2);
    b_sab <= (2*SW)'(rsa[SW-1:0]) * (2*SW)'(rsb[SW-1:0]);
    {b_dt, b_en, b_cb} <= i_side;
  end

  // stage C: cosphi dividend, rounded half up
  always_comb begin
    n_full = ({14'b0, $unsigned(b_dt)} << 14) + ({15'b0, b_den} >> 1);
    n_lim  = {b_den, 15'b0};
    c_pos  = b_en && (b_dt > 0) && (b_den != '0);
    c_big  = n_full >= n_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_pos && !c_big) begin
      c_num <= n_full;
      c_den <= b_den;
    end else begin
      c_num <= '0;
      c_den <= NW'(1);
    end
    c_side <= {!c_pos, c_big, b_cb, b_sab};
  end

  onf_div #(.NUM_W(N1W), .DEN_W(NW), .Q_W(PHW)) u_div_cphi (
    .clk (clk),
    .num (c_num),
    .den (c_den),
    .quo (q1)
  );

  onf_delay #(.W(SIDE2W), .DEPTH(PHW)) u_dly_cphi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_data   (c_side),
    .out_valid (j_valid),
    .out_data  (j_side)
  );

  assign {j_zero, j_big, j_cb, j_sab} = j_side;

  // stages D to F: clamp cosphi, B * cosphi * sin_a * sin_b
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      d_valid <= j_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (j_zero) begin
      d_cphi <= '0;
    end else if (j_big || q1 > onf_pkg::CPHI_ONE) begin
      d_cphi <= onf_pkg::CPHI_ONE;
    end else begin
      d_cphi <= q1;
    end
    d_cb  <= j_cb;
    d_sab <= j_sab;

    e_pb  <= (2*SW)'(coeff_b) * (2*SW)'(d_cphi);
    e_sab <= d_sab;
    e_cb  <= d_cb;

    f_prod <= (4*SW)'(e_pb) * (4*SW)'(e_sab);
    f_cb   <= e_cb;
  end

  // stage G: fold the 2^28 scale and its rounding into the dividend
  always_comb begin
    m      = SW'((f_cb < 0) ? -f_cb : f_cb);
    xs     = {1'b0, f_prod} + ({46'b0, m} << 27);
    xq     = xs[60:28];
    g_zero = (f_cb == '0);
    g_big  = {2'b0, xq} >= ({20'b0, m} << TQW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!g_zero && !g_big) begin
      g_num <= {2'b0, xq};
      g_den <= m;
    end else begin
      g_num <= '0;
      g_den <= SW'(1);
    end
    g_side <= {f_cb < 0, g_zero, g_big};
  end

  onf_div #(.NUM_W(N2W), .DEN_W(SW), .Q_W(TQW)) u_div_term (
    .clk (clk),
    .num (g_num),
    .den (g_den),
    .quo (q2)
  );

  onf_delay #(.W(3), .DEPTH(TQW)) u_dly_term (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_data   (g_side),
    .out_valid (h_valid),
    .out_data  (h_side)
  );

  assign {h_neg, h_zero, h_big} = h_side;

  // stage H: add A and saturate
  always_comb begin
    if (h_neg) begin
      h_sum = $signed({7'b0, coeff_a}) - $signed({2'b0, q2});
    end else begin
      h_sum = $signed({7'b0, coeff_a}) + $signed({2'b0, q2});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (h_zero) begin
      result.factor    <= onf_pkg::FACTOR_MAX;
      result.saturated <= 1'b1;
    end else if (h_big) begin
      result.factor    <= h_neg ? onf_pkg::FACTOR_MIN : onf_pkg::FACTOR_MAX;
      result.saturated <= 1'b1;
    end else if (h_sum > 22'sd262143) begin
      result.factor    <= onf_pkg::FACTOR_MAX;
      result.saturated <= 1'b1;
    end else if (h_sum < -22'sd262144) begin
      result.factor    <= onf_pkg::FACTOR_MIN;
      result.saturated <= 1'b1;
    end else begin
      result.factor    <= onf_pkg::FACTOR_W'(h_sum);
      result.saturated <= 1'b0;
    end
  end

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      (result.factor == onf_pkg::FACTOR_MAX || result.factor == onf_pkg::FACTOR_MIN))
    else $error("saturated result not at a range end");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    h_valid && h_zero |=> result_valid && result.saturated &&
      result.factor == onf_pkg::FACTOR_MAX)
    else $error("zero divisor did not give the positive rail");

  a_cphi_range: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> d_cphi <= onf_pkg::CPHI_ONE)
    else $error("azimuth cosine above one");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    fr_valid |-> fr.ci <= onf_pkg::COS_ONE && fr.ci >= -onf_pkg::COS_ONE &&
      fr.co <= onf_pkg::COS_ONE && fr.co >= -onf_pkg::COS_ONE)
    else $error("cosine outside clamp range");

endmodule
`default_nettype wire

>>> bench/oren_nayar_diffuse_factor_tb.sv
`default_nettype none
module oren_nayar_diffuse_factor_tb;

  localparam int LATENCY    = 72;
  localparam int STALL_CAP  = 4000;
  localparam int PHASE_ITEMS = 185;

  class factor_book;
    logic [onf_pkg::COEFF_W-1:0] coeff_a = onf_pkg::COEFF_A_RST;
    logic [onf_pkg::COEFF_W-1:0] coeff_b = onf_pkg::COEFF_B_RST;
    onf_pkg::out_item_t pending_factors[$];
    int errors = 0;

    function automatic logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - r - b;
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // dot product Q2.28 -> Q1.14, round half up, clamp to +-1
    function automatic longint clamp_cos(longint raw);
      longint c;
      c = (raw + 8192) >>> 14;
      if (c > onf_pkg::COS_ONE) c = onf_pkg::COS_ONE;
      if (c < -onf_pkg::COS_ONE) c = -onf_pkg::COS_ONE;
      return c;
    endfunction

    function automatic onf_pkg::out_item_t diffuse_factor(onf_pkg::in_item_t x);
      longint wi[3], wo[3], nv[3], p[3], q[3];
      longint ci, co, ca, cb, dt, n1, n2, res, term;
      logic [63:0] cphi, sa, sb, den, prod, mag, quo;
      bit sat;
      onf_pkg::out_item_t r;
      wi[0] = x.in_dir_x;  wi[1] = x.in_dir_y;  wi[2] = x.in_dir_z;
      wo[0] = x.out_dir_x; wo[1] = x.out_dir_y; wo[2] = x.out_dir_z;
      nv[0] = x.normal_x;  nv[1] = x.normal_y;  nv[2] = x.normal_z;
      ci = clamp_cos(wi[0] * nv[0] + wi[1] * nv[1] + wi[2] * nv[2]);
      co = clamp_cos(wo[0] * nv[0] + wo[1] * nv[1] + wo[2] * nv[2]);
      cphi = 0;
      sat = 0;
      if (ci < onf_pkg::COS_LIMIT && co < onf_pkg::COS_LIMIT) begin
        for (int k = 0; k < 3; k++) begin
          p[k] = (wi[k] * 16384 - nv[k] * ci + 128) >>> 8;
          q[k] = (wo[k] * 16384 - nv[k] * co + 128) >>> 8;
        end
        dt = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
        n1 = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
        n2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
        den = isqrt(64'(n1)) * isqrt(64'(n2));
        if (dt > 0 && den != 0) begin
          cphi = (64'(dt) * 16384 + den / 2) / den;
          if (cphi > onf_pkg::CPHI_ONE) cphi = onf_pkg::CPHI_ONE;
        end
      end
      if (co >= ci) begin
        cb = co; ca = ci;
      end else begin
        cb = ci; ca = co;
      end
      sa = isqrt(64'(268435456 - ca * ca));
      sb = isqrt(64'(268435456 - cb * cb));
      if (cb == 0) begin
        res = onf_pkg::FACTOR_MAX;
        sat = 1;
      end else begin
        prod = 64'(coeff_b) * cphi * sa * sb;
        mag = 64'(cb < 0 ? -cb : cb) << 28;
        quo = (prod + mag / 2) / mag;
        term = cb < 0 ? -longint'(quo) : longint'(quo);
        res = longint'(coeff_a) + term;
        if (res > onf_pkg::FACTOR_MAX) begin
          res = onf_pkg::FACTOR_MAX; sat = 1;
        end
        if (res < onf_pkg::FACTOR_MIN) begin
          res = onf_pkg::FACTOR_MIN; sat = 1;
        end
      end
      r.factor = res[onf_pkg::FACTOR_W-1:0];
      r.saturated = sat;
      return r;
    endfunction

    function void note_item(onf_pkg::in_item_t x);
      pending_factors = {pending_factors, diffuse_factor(x)};
    endfunction

    function void check_factor(onf_pkg::out_item_t got);
      onf_pkg::out_item_t want;
      if (pending_factors.size() == 0) begin
        $display("%0t: unexpected result factor=%0d sat=%0b", $time,
                 got.factor, got.saturated);
        errors++;
        return;
      end
      want = pending_factors.pop_front();
      if (got.factor !== want.factor) begin
        $display("%0t: factor expected %0d actual %0d", $time, want.factor, got.factor);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time,
                 want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, result_valid, cfg_valid, cfg_ready;
  onf_pkg::in_item_t item;
  onf_pkg::out_item_t result;
  logic [onf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [onf_pkg::COEFF_W-1:0] cfg_data;
  factor_book book;
  int idle_pct;
  int quiet_cycles;

  oren_nayar_diffuse_factor uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) book.check_factor(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_CAP) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(onf_pkg::in_item_t x);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    item <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_item(x);
  endtask

  task automatic drain();
    start <= 0;
    while (book.pending_factors.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [onf_pkg::CFG_IDX_W-1:0] idx,
                           logic [onf_pkg::COEFF_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == onf_pkg::REG_COEFF_A) book.coeff_a = val;
    else if (idx == onf_pkg::REG_COEFF_B) book.coeff_b = val;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] any_coord();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // near-unit vector, z computed from random x and y, negated at random
  function automatic void unit_vec(output logic signed [15:0] x, y, z, input int spread);
    longint r2;
    x = 16'($signed($urandom_range(2 * spread)) - spread);
    y = 16'($signed($urandom_range(2 * spread)) - spread);
    r2 = 268435456 - longint'(x) * x - longint'(y) * y;
    z = 16'(book.isqrt(64'(r2)));
    if ($urandom_range(3) == 0) z = -z;
  endfunction

  function automatic onf_pkg::in_item_t make(int a, b, c, d, e, f, g, h, i);
    onf_pkg::in_item_t x;
    x = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h), 16'(i)};
    return x;
  endfunction

  function automatic onf_pkg::in_item_t rand_item();
    onf_pkg::in_item_t x;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      unit_vec(x.in_dir_x, x.in_dir_y, x.in_dir_z, 11000);
      unit_vec(x.out_dir_x, x.out_dir_y, x.out_dir_z, 11000);
      unit_vec(x.normal_x, x.normal_y, x.normal_z, pick < 35 ? 3000 : 11000);
      if (pick < 8) x.out_dir_x = x.in_dir_x;
    end else begin
      x = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
           any_coord(), any_coord(), any_coord(), any_coord()};
      if (pick > 95) x.normal_z = 1;
    end
    return x;
  endfunction

  initial begin
    book = new();
    rst = 1;
    start = 0;
    item = '0;
    cfg_valid = 0;
    cfg_index = onf_pkg::REG_COEFF_A;
    cfg_data = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed, reset coefficients
    send_item(make(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));        // both along normal
    send_item(make(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));        // grazing: zero divisor
    send_item(make(0, 0, 0, 0, 0, 0, 0, 0, 0));                    // zero vectors
    send_item(make(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
    send_item(make(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384));
    send_item(make(-16384, 16384, -16384, 16384, -16384, 16384, 16384, 16384, -16384));
    send_item(make(11585, 0, 11585, -11585, 0, 11585, 0, 0, 16384)); // opposite azimuth
    send_item(make(11585, 0, 11585, 8192, 0, 14189, 0, 0, 16384));   // same azimuth
    send_item(make(11585, 0, -11585, 8192, 0, -14189, 0, 0, 16384)); // below surface
    send_item(make(16384, 0, 1, 16383, 0, 2, 0, 0, 16384));          // tiny cosines
    send_item(make(0, 0, 16383, 100, 0, 16383, 0, 0, 16384));        // at the limit
    send_item(make(-16384, 16384, 1, 16384, 16384, 1, 16384, 16384, 1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(onf_pkg::REG_COEFF_A, 0);
          write_reg(onf_pkg::REG_COEFF_B, 16384);
        end
        1: begin
          write_reg(onf_pkg::REG_COEFF_A, 16384);
          write_reg(onf_pkg::REG_COEFF_B, 0);
          write_reg(onf_pkg::CFG_IDX_W'(2), 15'($urandom));     // unmapped index, no effect
        end
        2: begin
          write_reg(onf_pkg::REG_COEFF_A, 32767);
          write_reg(onf_pkg::REG_COEFF_B, 32767);
        end
        default: begin
          write_reg(onf_pkg::REG_COEFF_A, 15'($urandom_range(16384)));
          write_reg(onf_pkg::REG_COEFF_B, 15'($urandom_range(16384)));
        end
      endcase
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 23 : 49;
      if (ph == 2) send_item(make(16384, 0, 1, 16384, 1, 1, 0, 0, 16384)); // overflow
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(rand_item());
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          start <= 0;
          while (book.pending_factors.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (book.errors == 0 && book.pending_factors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
src/onf_pkg.sv
src/onf_delay.sv
src/onf_isqrt.sv
src/onf_div.sv
src/onf_front.sv
src/oren_nayar_diffuse_factor.sv
bench/oren_nayar_diffuse_factor_tb.sv
